// ----- rtl/dq_pkg.sv -----
package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // operation codes carried in the op field
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CUR_FRONT  = 3'd4;
  localparam logic [2:0] OP_CUR_BACK   = 3'd5;
  localparam logic [2:0] OP_NEXT       = 3'd6;
  localparam logic [2:0] OP_PREV       = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic take;     // item accepted this cycle, commit pointer update
    logic load_rd;  // RAM read data is ready, load it into the result
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_rd;  // the pending item returns a stored word
    logic out_free; // result register can take a new result at this edge
  } dq_sts_t;

endpackage

// ----- rtl/dq_in_if.sv -----
interface dq_in_if #(
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

// ----- rtl/dq_out_if.sv -----
interface dq_out_if #(
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CNT_WIDTH  = $clog2(dq_pkg::DEPTH_DEF + 1)
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic                  data_valid;
  logic                  is_empty;
  logic [CNT_WIDTH-1:0]  entry_count;
  logic                  push_dropped;

  modport source (output valid, output data_out, output data_valid, output is_empty,
                  output entry_count, output push_dropped, input ready);
  modport sink   (input valid, input data_out, input data_valid, input is_empty,
                  input entry_count, input push_dropped, output ready);
endinterface

// ----- rtl/dq_ram.sv -----
module dq_ram #(
  parameter int unsigned WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dq_ctrl.sv -----
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dq_pkg::dq_sts_t sts_i,
  output dq_pkg::dq_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic take;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.take    = 1'b0;
    cmd_o.load_rd = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = take;
        if (take && sts_i.need_rd) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.load_rd = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_IDLE)
    else $error("read wait lasted more than one cycle");

  a_no_take_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !cmd_o.take)
    else $error("item taken while a read is pending");

endmodule

// ----- rtl/dq_dp.sv -----
module dq_dp #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IdxW      = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dq_pkg::dq_cmd_t       cmd_i,
  output dq_pkg::dq_sts_t       sts_o,
  input  logic [2:0]            op_i,
  input  logic [DATA_WIDTH-1:0] data_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] data_out_o,
  output logic                  data_valid_o,
  output logic                  is_empty_o,
  output logic [CntW-1:0]       entry_count_o,
  output logic                  push_dropped_o
);

  localparam int unsigned SumW = CntW + 1;

  logic [IdxW-1:0] head_q, head_d, cur_q, cur_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            live_q, live_d;

  logic            full, empty;
  logic [SumW-1:0] sum, sum_m1, back_raw, tail_raw;
  logic [IdxW-1:0] back_slot, tail, tail_dec;
  logic [IdxW-1:0] head_inc, head_dec, cur_inc, cur_dec;

  logic            wr_en, need_rd, dropped;
  logic [IdxW-1:0] wr_addr, rd_addr, slot;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] data_out_q;
  logic                  data_valid_q, is_empty_q, dropped_q;
  logic [CntW-1:0]       count_q;

  assign full  = fill_q == CntW'(DEPTH);
  assign empty = fill_q == '0;

  // ring positions; sums stay below twice DEPTH, so one subtract wraps them
  assign sum       = SumW'(head_q) + SumW'(fill_q);
  assign sum_m1    = sum - SumW'(1);
  assign back_raw  = (sum >= SumW'(DEPTH)) ? sum - SumW'(DEPTH) : sum;
  assign tail_raw  = (sum_m1 >= SumW'(DEPTH)) ? sum_m1 - SumW'(DEPTH) : sum_m1;
  assign back_slot = back_raw[IdxW-1:0];
  assign tail      = tail_raw[IdxW-1:0];

  assign head_inc = (head_q == IdxW'(DEPTH - 1)) ? '0 : head_q + IdxW'(1);
  assign head_dec = (head_q == '0) ? IdxW'(DEPTH - 1) : head_q - IdxW'(1);
  assign cur_inc  = (cur_q == IdxW'(DEPTH - 1)) ? '0 : cur_q + IdxW'(1);
  assign cur_dec  = (cur_q == '0) ? IdxW'(DEPTH - 1) : cur_q - IdxW'(1);
  assign tail_dec = (tail == '0) ? IdxW'(DEPTH - 1) : tail - IdxW'(1);

  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    cur_d   = cur_q;
    live_d  = live_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    need_rd = 1'b0;
    rd_addr = cur_q;
    dropped = 1'b0;
    slot    = head_q;
    case (op_i)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          wr_en = 1'b1;
          if (empty) begin
            wr_addr = head_q;
            cur_d   = head_q;
            live_d  = 1'b1;
          end else if (op_i == dq_pkg::OP_PUSH_FRONT) begin
            head_d  = head_dec;
            wr_addr = head_dec;
          end else begin
            wr_addr = back_slot;
          end
          fill_d = fill_q + CntW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (!empty) begin
          slot    = (op_i == dq_pkg::OP_POP_FRONT) ? head_q : tail;
          need_rd = 1'b1;
          rd_addr = slot;
          if (fill_q == CntW'(1)) begin
            fill_d = '0;
            live_d = 1'b0;
          end else begin
            fill_d = fill_q - CntW'(1);
            if (op_i == dq_pkg::OP_POP_FRONT) begin
              head_d = head_inc;
            end
            // entry under the cursor leaves: cursor goes to the new end
            if (live_q && cur_q == slot) begin
              cur_d = (op_i == dq_pkg::OP_POP_FRONT) ? head_inc : tail_dec;
            end
          end
        end
      end
      dq_pkg::OP_CUR_FRONT, dq_pkg::OP_CUR_BACK: begin
        if (empty) begin
          live_d = 1'b0;
        end else begin
          cur_d  = (op_i == dq_pkg::OP_CUR_FRONT) ? head_q : tail;
          live_d = 1'b1;
        end
      end
      dq_pkg::OP_NEXT, dq_pkg::OP_PREV: begin
        if (live_q && !empty) begin
          need_rd = 1'b1;
          rd_addr = cur_q;
          if (op_i == dq_pkg::OP_NEXT) begin
            if (cur_q == tail) live_d = 1'b0;
            else               cur_d  = cur_inc;
          end else begin
            if (cur_q == head_q) live_d = 1'b0;
            else                 cur_d  = cur_dec;
          end
        end
      end
      default: begin
        need_rd = 1'b0;
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (data_in_i),
    .re_i    (cmd_i.take && need_rd),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign sts_o.need_rd  = need_rd;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      cur_q       <= '0;
      live_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        head_q <= head_d;
        fill_q <= fill_d;
        cur_q  <= cur_d;
        live_q <= live_d;
      end
      if ((cmd_i.take && !need_rd) || cmd_i.load_rd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_out_q   <= '0;
      data_valid_q <= need_rd;
      is_empty_q   <= fill_d == '0;
      count_q      <= fill_d;
      dropped_q    <= dropped;
    end else if (cmd_i.load_rd) begin
      data_out_q <= rd_data;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_out_o     = data_out_q;
  assign data_valid_o   = data_valid_q;
  assign is_empty_o     = is_empty_q;
  assign entry_count_o  = count_q;
  assign push_dropped_o = dropped_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(DEPTH))
    else $error("fill count beyond ring depth");

  a_live_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> fill_q != '0)
    else $error("cursor live on an empty queue");

  a_drop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && dropped |=> fill_q == $past(fill_q) && head_q == $past(head_q))
    else $error("dropped push changed the queue");

endmodule

// ----- rtl/deque_with_cursor.sv -----
// Double-ended queue of data words with a traversal cursor.
//
// Input channel in_i carries op and data_in; an item is taken when valid and
// ready are both high. op selects push front/back, pop front/back, cursor to
// front/back, or read at the cursor and step next/prev. Every item yields one
// result on out_o: the popped or read word with data_valid, the entry count
// and empty flag after the operation, and push_dropped for a push into a full
// ring.
//
// Pushes and cursor placement load the output register at the accepting
// edge, so the result is offered in the next cycle; pops and cursor reads
// of a stored word pass the registered read port of the ring RAM and the
// S_READ state, in which no new item is taken. Pushes and cursor placement
// run at one item per cycle while the receiver keeps ready high.
//
// Reset empties the queue and invalidates the cursor; the ring contents are
// not cleared. When the receiver holds ready low, the result stays in the
// output register and no new item is taken until it leaves.
module deque_with_cursor #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  dq_pkg::dq_cmd_t cmd;
  dq_pkg::dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (in_i.op),
    .data_in_i      (in_i.data_in),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .data_out_o     (out_o.data_out),
    .data_valid_o   (out_o.data_valid),
    .is_empty_o     (out_o.is_empty),
    .entry_count_o  (out_o.entry_count),
    .push_dropped_o (out_o.push_dropped)
  );

endmodule
